// File: rtl/bcx_pkg.sv
// Shared types and constants for the beacon SSID/channel extractor.
`default_nettype none
package bcx_pkg;

	typedef enum logic [2:0] {
		PH_RADIOTAP = 3'd0,
		PH_SKIP     = 3'd1,
		PH_ID       = 3'd2,
		PH_LEN      = 3'd3,
		PH_BODY     = 3'd4,
		PH_SSID     = 3'd5,
		PH_DS       = 3'd6
	} phase_t;

	localparam logic [7:0]  FIXED_SKIP  = 8'd36;
	localparam logic [7:0]  ID_SSID     = 8'd0;
	localparam logic [7:0]  ID_DS       = 8'd3;
	localparam logic [7:0]  CNT_MAX     = 8'hFF;
	localparam logic [15:0] POS_MAX     = 16'hFFFF;
	localparam logic [15:0] LEN_LO_POS  = 16'd2;
	localparam logic [15:0] LEN_HI_POS  = 16'd3;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	// Everything one input byte produces: an optional SSID byte and an
	// optional frame summary.
	typedef struct packed {
		logic       has_ssid;
		logic [7:0] ssid;
		logic       has_sum;
		logic [7:0] chan;
		logic       ssid_f;
		logic       chan_f;
		logic [7:0] slen;
	} byte_res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage
`default_nettype wire

// File: rtl/bcx_parser.sv
// Frame parser: header skip, element walk and per-frame bookkeeping.
`default_nettype none
module bcx_parser import bcx_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       go,
	input  wire logic [7:0] data_byte,
	input  wire logic       frame_end,
	output logic            push,
	output byte_res_t       res
);

	phase_t      phase_q, phase_n;
	logic [15:0] pos_q, pos_n;
	logic [15:0] rl_q, rl_n;
	logic [7:0]  id_q, id_n;
	logic [7:0]  rem_q, rem_n;
	logic        ssid_seen_q, ssid_seen_n;
	logic        chan_seen_q, chan_seen_n;
	logic [7:0]  chan_val_q, chan_val_n;
	logic [7:0]  cnt_q, cnt_n;
	logic [7:0]  rem_dec;

	assign rem_dec = rem_q - 8'd1;

	// next state and datapath
	always_comb begin
		phase_n     = phase_q;
		rl_n        = rl_q;
		id_n        = id_q;
		rem_n       = rem_q;
		ssid_seen_n = ssid_seen_q;
		chan_seen_n = chan_seen_q;
		chan_val_n  = chan_val_q;
		cnt_n       = cnt_q;
		pos_n       = (pos_q != POS_MAX) ? pos_q + 16'd1 : pos_q;
		case (phase_q)
			PH_RADIOTAP: begin
				if (pos_q == LEN_LO_POS) begin
					rl_n[7:0] = data_byte;
				end else if (pos_q == LEN_HI_POS) begin
					rl_n[15:8] = data_byte;
				end
				// lengths below 4 end the header right after the length bytes
				if (pos_q >= LEN_HI_POS && ({1'b0, pos_q} + 17'd1) >= {1'b0, rl_n}) begin
					phase_n = PH_SKIP;
					rem_n   = FIXED_SKIP;
				end
			end
			PH_SKIP: begin
				rem_n   = rem_dec;
				phase_n = (rem_dec == 8'd0) ? PH_ID : PH_SKIP;
			end
			PH_ID: begin
				id_n    = data_byte;
				phase_n = PH_LEN;
			end
			PH_LEN: begin
				rem_n = data_byte;
				if (id_q == ID_SSID && !ssid_seen_q) begin
					ssid_seen_n = 1'b1;
					phase_n     = (data_byte == 8'd0) ? PH_ID : PH_SSID;
				end else if (id_q == ID_DS && !chan_seen_q) begin
					phase_n = (data_byte == 8'd0) ? PH_ID : PH_DS;
				end else begin
					phase_n = (data_byte == 8'd0) ? PH_ID : PH_BODY;
				end
			end
			PH_SSID: begin
				if (cnt_q != CNT_MAX) begin
					cnt_n = cnt_q + 8'd1;
				end
				rem_n   = rem_dec;
				phase_n = (rem_dec == 8'd0) ? PH_ID : PH_SSID;
			end
			PH_DS: begin
				chan_val_n  = data_byte;
				chan_seen_n = 1'b1;
				rem_n       = rem_dec;
				phase_n     = (rem_dec == 8'd0) ? PH_ID : PH_BODY;
			end
			PH_BODY: begin
				rem_n   = rem_dec;
				phase_n = (rem_dec == 8'd0) ? PH_ID : PH_BODY;
			end
			default: begin
				phase_n = PH_ID;
			end
		endcase
	end

	// outputs: summary reflects the state after this byte
	always_comb begin
		res.has_ssid = (phase_q == PH_SSID);
		res.ssid     = data_byte;
		res.has_sum  = frame_end;
		res.chan     = chan_seen_n ? chan_val_n : 8'd0;
		res.ssid_f   = ssid_seen_n;
		res.chan_f   = chan_seen_n;
		res.slen     = cnt_n;
		push         = go && (res.has_ssid || frame_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_RADIOTAP;
			pos_q       <= '0;
			rl_q        <= '0;
			id_q        <= '0;
			rem_q       <= '0;
			ssid_seen_q <= 1'b0;
			chan_seen_q <= 1'b0;
			chan_val_q  <= '0;
			cnt_q       <= '0;
		end else if (go) begin
			if (frame_end) begin
				phase_q     <= PH_RADIOTAP;
				pos_q       <= '0;
				rl_q        <= '0;
				id_q        <= '0;
				rem_q       <= '0;
				ssid_seen_q <= 1'b0;
				chan_seen_q <= 1'b0;
				chan_val_q  <= '0;
				cnt_q       <= '0;
			end else begin
				phase_q     <= phase_n;
				pos_q       <= pos_n;
				rl_q        <= rl_n;
				id_q        <= id_n;
				rem_q       <= rem_n;
				ssid_seen_q <= ssid_seen_n;
				chan_seen_q <= chan_seen_n;
				chan_val_q  <= chan_val_n;
				cnt_q       <= cnt_n;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/bcx_outq.sv
// Small result queue holding per-byte result groups until they are taken.
`default_nettype none
module bcx_outq import bcx_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire byte_res_t wr_res,
	input  wire logic      pop,
	output byte_res_t      head,
	output q_status_t      status
);

	byte_res_t            mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [Q_PTR_W:0]     count_q;
	logic                 do_push, do_pop;

	assign status       = '{full: (count_q == (Q_PTR_W + 1)'(Q_DEPTH)),
	                        empty: (count_q == '0)};
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/beacon_ssid_channel_extractor.sv
// Top level of the beacon SSID/channel extractor.
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------------------
//   in      | in_valid / in_stall   | data_byte, frame_end
//   out     | out_valid / out_stall | kind, ssid_byte, channel_number, ssid_found,
//           |                       | channel_found, ssid_length, last
//
// A byte is captured in the input register when taken and parsed from there once
// the result queue has room; its results then show from the queue. A byte that
// yields an SSID byte and the summary puts out two transactions, SSID byte first.
// Sustained rate is one byte per cycle while in_stall is low; the two-entry result
// queue fills while out_stall holds results back or while an entry with an SSID
// byte and a summary is put out; in_stall rises only while it is full. Reset
// clears parser state and the queue; state also resets after every frame_end byte.
`default_nettype none
module beacon_ssid_channel_extractor import bcx_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       frame_end,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            kind,
	output logic [7:0]      ssid_byte,
	output logic [7:0]      channel_number,
	output logic            ssid_found,
	output logic            channel_found,
	output logic [7:0]      ssid_length,
	output logic            last
);

	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       frame_end_s1;
	logic       go;
	logic       push;
	logic       pop;
	logic       sel_q;
	logic       show_ssid;
	byte_res_t  res;
	byte_res_t  head;
	q_status_t  qs;

	assign go       = valid_s1 && !qs.full;
	assign in_stall = valid_s1 && qs.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_byte_s1 <= data_byte;
			frame_end_s1 <= frame_end;
		end
	end

	bcx_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.data_byte (data_byte_s1),
		.frame_end (frame_end_s1),
		.push      (push),
		.res       (res)
	);

	bcx_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_res (res),
		.pop    (pop),
		.head   (head),
		.status (qs)
	);

	// sel_q steps from the SSID byte to the summary within one queue entry
	assign show_ssid = head.has_ssid && !sel_q;
	assign out_valid = !qs.empty;
	assign pop       = out_valid && !out_stall && (!show_ssid || !head.has_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			sel_q <= show_ssid && head.has_sum;
		end
	end

	always_comb begin
		kind           = !show_ssid;
		ssid_byte      = show_ssid ? head.ssid : 8'd0;
		channel_number = show_ssid ? 8'd0 : head.chan;
		ssid_found     = !show_ssid && head.ssid_f;
		channel_found  = !show_ssid && head.chan_f;
		ssid_length    = show_ssid ? 8'd0 : head.slen;
		last           = !show_ssid || !head.has_sum;
	end

endmodule
`default_nettype wire

// File: rtl/bcx_checker.sv
// Port-level checks for the beacon SSID/channel extractor, bound to the top.
`default_nettype none
module bcx_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       kind,
	input wire logic [7:0] ssid_byte,
	input wire logic [7:0] channel_number,
	input wire logic       ssid_found,
	input wire logic       channel_found,
	input wire logic [7:0] ssid_length,
	input wire logic       last
);

	// a summary always closes the group of one byte
	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> last)
		else $error("summary transaction without last");

	a_ssid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind |-> channel_number == 8'd0 && !ssid_found && !channel_found
			&& ssid_length == 8'd0)
		else $error("SSID transaction carries summary fields");

	a_chan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind && !channel_found |-> channel_number == 8'd0)
		else $error("channel reported without DS element");

	// an SSID byte not marked last and not stalled is followed at once by its summary
	a_sum_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind && !last && !out_stall |=> out_valid && kind)
		else $error("missing summary after SSID byte");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(ssid_byte)
			&& $stable(last) && $stable(ssid_length))
		else $error("stalled transaction changed");

endmodule

bind beacon_ssid_channel_extractor bcx_checker u_bcx_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.kind           (kind),
	.ssid_byte      (ssid_byte),
	.channel_number (channel_number),
	.ssid_found     (ssid_found),
	.channel_found  (channel_found),
	.ssid_length    (ssid_length),
	.last           (last)
);
`default_nettype wire

// File: dv/beacon_ssid_channel_extractor_tb.sv
// Self-checking testbench for the beacon SSID/channel extractor: directed and random frames.
`timescale 1ns / 1ps
module beacon_ssid_channel_extractor_tb import bcx_pkg::*; ();

	localparam logic KIND_SSID    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;
	localparam int   STALL_LIMIT  = 2000;
	localparam int   DRAIN_CYCLES = 8;

	typedef struct {
		logic       kind;
		logic [7:0] ssid;
		logic [7:0] chan;
		logic       ssid_f;
		logic       chan_f;
		logic [7:0] slen;
		logic       last;
	} extract_res_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'd0;
	logic       frame_end = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       kind;
	logic [7:0] ssid_byte;
	logic [7:0] channel_number;
	logic       ssid_found;
	logic       channel_found;
	logic [7:0] ssid_length;
	logic       last;

	beacon_ssid_channel_extractor DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.frame_end     (frame_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.ssid_byte     (ssid_byte),
		.channel_number(channel_number),
		.ssid_found    (ssid_found),
		.channel_found (channel_found),
		.ssid_length   (ssid_length),
		.last          (last)
	);

	always #5 clk = ~clk;

	// parser state mirror
	logic [15:0] pm_pos;
	logic [15:0] pm_rt_len;
	phase_t      pm_phase;
	logic [7:0]  pm_elem_id;
	logic [7:0]  pm_elem_rem;
	logic        pm_ssid_seen;
	logic        pm_chan_seen;
	logic [7:0]  pm_chan;
	logic [7:0]  pm_ssid_cnt;

	extract_res_t pending_results[$];
	logic [7:0]   frame_q[$];

	int idle_pct = 0;
	int stall_pct = 0;
	int err_cnt = 0;
	int frames_sent = 0;
	int bytes_sent = 0;
	int results_checked = 0;
	int quiet_cycles = 0;

	task automatic parser_clear();
		pm_pos       = 16'd0;
		pm_rt_len    = 16'd0;
		pm_phase     = PH_RADIOTAP;
		pm_elem_id   = 8'd0;
		pm_elem_rem  = 8'd0;
		pm_ssid_seen = 1'b0;
		pm_chan_seen = 1'b0;
		pm_chan      = 8'd0;
		pm_ssid_cnt  = 8'd0;
	endtask

	task automatic count_down_element();
		pm_elem_rem = pm_elem_rem - 8'd1;
		if (pm_elem_rem == 8'd0) pm_phase = PH_ID;
	endtask

	task automatic expect_result(input extract_res_t r);
		pending_results.insert(pending_results.size(), r);
	endtask

	task automatic add_byte(input logic [7:0] b);
		frame_q.insert(frame_q.size(), b);
	endtask

	task automatic predict_frame_byte(input logic [7:0] b, input logic e);
		extract_res_t r;
		case (pm_phase)
			PH_RADIOTAP: begin
				if (pm_pos == LEN_LO_POS) pm_rt_len[7:0] = b;
				else if (pm_pos == LEN_HI_POS) pm_rt_len[15:8] = b;
				// header ends at its length, never before the length bytes
				if (pm_pos >= LEN_HI_POS
					&& ({1'b0, pm_pos} + 17'd1) >= {1'b0, pm_rt_len}) begin
					pm_phase    = PH_SKIP;
					pm_elem_rem = FIXED_SKIP;
				end
			end
			PH_SKIP: count_down_element();
			PH_ID: begin
				pm_elem_id = b;
				pm_phase   = PH_LEN;
			end
			PH_LEN: begin
				pm_elem_rem = b;
				if (pm_elem_id == ID_SSID && !pm_ssid_seen) begin
					pm_ssid_seen = 1'b1;
					pm_phase = (b == 8'd0) ? PH_ID : PH_SSID;
				end else if (pm_elem_id == ID_DS && !pm_chan_seen) begin
					pm_phase = (b == 8'd0) ? PH_ID : PH_DS;
				end else begin
					pm_phase = (b == 8'd0) ? PH_ID : PH_BODY;
				end
			end
			PH_SSID: begin
				r = '{kind: KIND_SSID, ssid: b, chan: 8'd0, ssid_f: 1'b0, chan_f: 1'b0,
					slen: 8'd0, last: !e};
				expect_result(r);
				if (pm_ssid_cnt != CNT_MAX) pm_ssid_cnt = pm_ssid_cnt + 8'd1;
				count_down_element();
			end
			PH_DS: begin
				pm_chan      = b;
				pm_chan_seen = 1'b1;
				pm_phase     = PH_BODY;
				count_down_element();
			end
			PH_BODY: count_down_element();
			default: pm_phase = PH_ID;
		endcase
		if (pm_pos != POS_MAX) pm_pos = pm_pos + 16'd1;
		if (e) begin
			r = '{kind: KIND_SUMMARY, ssid: 8'd0, chan: pm_chan_seen ? pm_chan : 8'd0,
				ssid_f: pm_ssid_seen, chan_f: pm_chan_seen, slen: pm_ssid_cnt, last: 1'b1};
			expect_result(r);
			parser_clear();
		end
	endtask

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			err_cnt++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		extract_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected transaction: expected none, actual kind %0b ssid %0h",
					$time, kind, ssid_byte);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				check_field("kind", 8'(want.kind), 8'(kind));
				check_field("ssid_byte", want.ssid, ssid_byte);
				check_field("channel_number", want.chan, channel_number);
				check_field("ssid_found", 8'(want.ssid_f), 8'(ssid_found));
				check_field("channel_found", 8'(want.chan_f), 8'(channel_found));
				check_field("ssid_length", want.slen, ssid_length);
				check_field("last", 8'(want.last), 8'(last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// one byte; valid stays high from one transaction into the next unless idle cycles are drawn
	task automatic send_byte(input logic [7:0] b, input logic e);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		frame_end <= e;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_frame_byte(b, e);
		bytes_sent++;
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic put_radiotap(input logic [15:0] len_field);
		int n;
		n = (len_field < 16'd4) ? 4 : int'(len_field);
		add_byte(8'($urandom));
		add_byte(8'($urandom));
		add_byte(len_field[7:0]);
		add_byte(len_field[15:8]);
		for (int i = 4; i < n; i++) add_byte(8'($urandom));
	endtask

	// 802.11 header plus beacon fixed fields
	task automatic put_fixed();
		repeat (FIXED_SKIP) add_byte(8'($urandom));
	endtask

	task automatic put_element(input logic [7:0] id, input int len, input logic [7:0] first);
		add_byte(id);
		add_byte(8'(len));
		for (int i = 0; i < len; i++) add_byte((i == 0) ? first : 8'($urandom));
	endtask

	// keep == 0 sends the whole frame, otherwise only its first keep bytes
	task automatic send_frame(input int keep);
		int n;
		n = (keep <= 0 || keep > frame_q.size()) ? frame_q.size() : keep;
		for (int i = 0; i < n; i++) send_byte(frame_q[i], i == n - 1);
		frame_q.delete();
		frames_sent++;
	endtask

	task automatic test_radiotap_lengths();
		logic [15:0] lens[2] = '{16'd0, 16'd9};
		foreach (lens[i]) begin
			put_radiotap(lens[i]);
			put_fixed();
			put_element(ID_SSID, 2, 8'h41);
			put_element(ID_DS, 1, 8'd6);
			send_frame(0);
		end
		wait_for_results();
	endtask

	task automatic test_ssid_elements();
		// empty first SSID, later SSID not emitted
		put_radiotap(16'd8);
		put_fixed();
		put_element(ID_SSID, 0, 8'h00);
		put_element(ID_SSID, 3, 8'h42);
		put_element(ID_DS, 1, 8'd11);
		send_frame(0);
		// longer SSID, then a second one that is skipped
		put_radiotap(16'd4);
		put_fixed();
		put_element(ID_SSID, 16, 8'hFF);
		put_element(ID_SSID, 2, 8'h00);
		send_frame(0);
		wait_for_results();
	endtask

	task automatic test_ds_elements();
		// empty DS is skipped; the next DS gives the channel; a third is ignored
		put_radiotap(16'd6);
		put_fixed();
		put_element(ID_DS, 0, 8'h00);
		put_element(ID_DS, 2, 8'h00);
		put_element(ID_DS, 1, 8'hFF);
		send_frame(0);
		wait_for_results();
	endtask

	task automatic test_truncated_frames();
		// header 0..7, fixed 8..43, SSID id/len 44/45, body 46..49, DS 50..52
		// cut inside the length bytes, and on an SSID byte (two transactions)
		int cuts[2] = '{3, 48};
		foreach (cuts[i]) begin
			put_radiotap(16'd8);
			put_fixed();
			put_element(ID_SSID, 4, 8'h61);
			put_element(ID_DS, 1, 8'd36);
			send_frame(cuts[i]);
		end
		wait_for_results();
	endtask

	task automatic test_random_frames(input int idle, input int stall, input int bytes_goal);
		int start;
		int n_el;
		int pick;
		int len;
		int cut;
		logic [7:0] id;
		idle_pct  = idle;
		stall_pct = stall;
		start = bytes_sent;
		while (bytes_sent - start < bytes_goal) begin
			if ($urandom_range(0, 99) < 15) begin
				// noise: raw bytes, often cut inside the header
				len = $urandom_range(1, 50);
				repeat (len) add_byte(8'($urandom));
				send_frame(0);
			end else begin
				put_radiotap(($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 40))
					: 16'($urandom_range(0, 12)));
				put_fixed();
				n_el = $urandom_range(0, 6);
				repeat (n_el) begin
					pick = $urandom_range(0, 9);
					id = (pick < 3) ? ID_SSID : (pick < 6) ? ID_DS : 8'($urandom);
					len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
						: $urandom_range(0, 8);
					put_element(id, len, 8'($urandom));
				end
				cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, frame_q.size()) : 0;
				send_frame(cut);
			end
		end
		wait_for_results();
	endtask

	initial begin
		parser_clear();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_radiotap_lengths();
		test_ssid_elements();
		test_ds_elements();
		test_truncated_frames();
		test_random_frames(0, 0, 30);
		test_random_frames(79, 0, 30);
		test_random_frames(0, 79, 30);
		test_random_frames(24, 24, 30);

		idle_pct  = 0;
		stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			err_cnt++;
			$display("%0t: %0d expected transactions never arrived", $time, pending_results.size());
		end

		$display("Run covered %0d frames (%0d bytes, %0d results checked, %0d mismatches)",
			frames_sent, bytes_sent, results_checked, err_cnt);
		$display("with short radiotap headers, SSID/DS corner cases, truncation, idle/stall mixes");
		if (err_cnt == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
